// ----- sv/mtfkc_pkg.sv -----
// Shared types and constants for the move-to-front key cache.
// No dependencies; imported by every module of the block.
package mtfkc_pkg;

    // Key field widths and the packed key {x, y, level}
    localparam int X_W    = 32;
    localparam int Y_W    = 32;
    localparam int LVL_W  = 16;
    localparam int KEY_W  = X_W + Y_W + LVL_W;
    localparam int SLOT_W = 4;

    // Default number of cache entries
    localparam int MTFKC_ENTRIES = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the key, clear the scan trackers
        logic scan_issue;  // read one entry for the lookup pass
        logic age_issue;   // read one entry for the aging pass
        logic commit;      // write the target slot and the result
    } mtfkc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_last;    // entry counter is on the last entry
    } mtfkc_status_t;

endpackage

// ----- sv/move_to_front_key_cache.sv -----
// Top level of the move-to-front key cache: controller plus datapath.
// Depends on mtfkc_pkg, mtfkc_ctrl and mtfkc_dpath.
//
//   channel | handshake      | payload
//   --------+----------------+-----------------------------------
//   lookup  | start / busy   | tile_x, tile_y, zoom_level
//   result  | done (strobe)  | hit, slot, evicted
//
// An item is taken when start is high and busy is low. busy then stays high
// through one pass over the key and rank memories for the lookup, one
// read-modify-write pass over the rank memory for aging, and a commit
// step. done pulses for one cycle as busy falls; the next item may be
// started in that same cycle. Reset clears all valid bits at once.
// The receiver cannot stall the result.
module move_to_front_key_cache
    import mtfkc_pkg::*;
#(
    parameter int CACHE_ENTRIES = MTFKC_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [X_W-1:0]    tile_x,
    input  logic [Y_W-1:0]    tile_y,
    input  logic [LVL_W-1:0]  zoom_level,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              evicted
);

    mtfkc_cmd_t    cmd;
    mtfkc_status_t status;

    mtfkc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mtfkc_dpath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .tile_x     (tile_x),
        .tile_y     (tile_y),
        .zoom_level (zoom_level),
        .hit        (hit),
        .slot       (slot),
        .evicted    (evicted)
    );

endmodule

// ----- sv/mtfkc_ctrl.sv -----
// Controller state machine of the move-to-front key cache.
// Depends on mtfkc_pkg; drives the datapath through mtfkc_cmd_t.
module mtfkc_ctrl
    import mtfkc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mtfkc_status_t status,
    output mtfkc_cmd_t    cmd,
    output logic          busy,
    output logic          done
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_AGE      = 3'd3;
    localparam logic [2:0] ST_AGE_END  = 3'd4;
    localparam logic [2:0] ST_COMMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                cmd.age_issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_AGE_END;
                end
            end
            ST_AGE_END:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_COMMIT);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- sv/mtfkc_dpath.sv -----
// Datapath of the move-to-front key cache: key and rank memories, valid bits,
// scan trackers, aging pass and result registers. Depends on mtfkc_pkg.
module mtfkc_dpath
    import mtfkc_pkg::*;
#(
    parameter int CACHE_ENTRIES = MTFKC_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mtfkc_cmd_t          cmd,
    output mtfkc_status_t       status,
    input  logic [X_W-1:0]      tile_x,
    input  logic [Y_W-1:0]      tile_y,
    input  logic [LVL_W-1:0]    zoom_level,
    output logic                hit,
    output logic [SLOT_W-1:0]   slot,
    output logic                evicted
);

    localparam int IW    = $clog2(CACHE_ENTRIES);
    localparam int EXT_W = SLOT_W + IW;
    localparam logic [IW-1:0] IDX_LAST = IW'(CACHE_ENTRIES - 1);
    localparam logic [IW-1:0] IDX_ONE  = IW'(1);

    // Storage
    logic [KEY_W-1:0]         key_mem  [CACHE_ENTRIES];
    logic [IW-1:0]            rank_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;

    // Item key and entry counter
    logic [KEY_W-1:0] key_reg;
    logic [IW-1:0]    idx_reg;

    // Read stage
    logic [KEY_W-1:0] key_rd_reg;
    logic [IW-1:0]    rank_rd_reg;
    logic [IW-1:0]    p_idx_reg;
    logic             p_valid_reg;
    logic             p_age_reg;

    // Scan trackers
    logic          found_reg;
    logic [IW-1:0] hit_slot_reg;
    logic [IW-1:0] hit_rank_reg;
    logic          free_reg;
    logic [IW-1:0] free_slot_reg;
    logic [IW-1:0] lru_slot_reg;
    logic [IW-1:0] lru_rank_reg;

    // Result registers
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              evicted_reg;

    logic              entry_v;
    logic              evict;
    logic [IW-1:0]     target;
    logic [EXT_W-1:0]  target_ext;
    logic              age_wr;
    logic              rank_we;
    logic [IW-1:0]     rank_waddr;
    logic [IW-1:0]     rank_wdata;

    assign status.idx_last = (idx_reg == IDX_LAST);
    assign entry_v         = valid_reg[p_idx_reg];

    // Replacement decision from the finished scan
    assign evict  = !found_reg && !free_reg;
    always_comb
    begin
        if (found_reg)
        begin
            target = hit_slot_reg;
        end
        else if (free_reg)
        begin
            target = free_slot_reg;
        end
        else
        begin
            target = lru_slot_reg;
        end
    end
    assign target_ext = EXT_W'(target);

    // Aging: on a hit, entries more recent than the hit move back one place;
    // on a miss, every valid entry except the one being replaced does
    always_comb
    begin
        age_wr = 1'b0;
        if (p_valid_reg && p_age_reg && entry_v)
        begin
            if (found_reg)
            begin
                age_wr = (rank_rd_reg < hit_rank_reg);
            end
            else
            begin
                age_wr = !(evict && (p_idx_reg == target));
            end
        end
    end

    // Rank memory write port: aging pass or commit
    always_comb
    begin
        rank_we    = age_wr || cmd.commit;
        rank_waddr = cmd.commit ? target : p_idx_reg;
        rank_wdata = cmd.commit ? '0 : (rank_rd_reg + IDX_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (cmd.scan_issue || cmd.age_issue)
        begin
            rank_rd_reg <= rank_mem[idx_reg];
        end
    end

    // Key memory: written on a miss, read during the lookup pass
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !found_reg)
        begin
            key_mem[target] <= key_reg;
        end
        if (cmd.scan_issue)
        begin
            key_rd_reg <= key_mem[idx_reg];
        end
    end

    // Item key and read stage bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= {tile_x, tile_y, zoom_level};
        end
        p_idx_reg <= idx_reg;
        p_age_reg <= cmd.age_issue;
    end

    // Control state: counter, stage valid, valid bits, trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            p_valid_reg <= 1'b0;
            valid_reg   <= '0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.scan_issue || cmd.age_issue;

            // entry counter wraps after the last entry
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_issue || cmd.age_issue)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : (idx_reg + IDX_ONE);
            end

            if (cmd.capture)
            begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (p_valid_reg && !p_age_reg)
            begin
                if (entry_v)
                begin
                    if (!found_reg && (key_rd_reg == key_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else if (!free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                valid_reg[target] <= 1'b1;
            end
        end
    end

    // Tracker payload: first match, first free slot, oldest valid entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lru_rank_reg <= '0;
            lru_slot_reg <= '0;
        end
        else if (p_valid_reg && !p_age_reg)
        begin
            if (entry_v)
            begin
                if (!found_reg && (key_rd_reg == key_reg))
                begin
                    hit_slot_reg <= p_idx_reg;
                    hit_rank_reg <= rank_rd_reg;
                end
                if (rank_rd_reg >= lru_rank_reg)
                begin
                    lru_rank_reg <= rank_rd_reg;
                    lru_slot_reg <= p_idx_reg;
                end
            end
            else if (!free_reg)
            begin
                free_slot_reg <= p_idx_reg;
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg     <= found_reg;
            slot_reg    <= target_ext[SLOT_W-1:0];
            evicted_reg <= evict;
        end
    end

    assign hit     = hit_reg;
    assign slot    = slot_reg;
    assign evicted = evicted_reg;

endmodule

// ----- sv/mtfkc_checker.sv -----
// Port-level checks for the move-to-front key cache, bound to the top level.
// Depends on mtfkc_pkg and move_to_front_key_cache.
module mtfkc_checker
    import mtfkc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              hit,
    input logic [SLOT_W-1:0] slot,
    input logic              evicted
);

    // An accepted item makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but busy did not rise");

    // The result comes exactly when the work ends
    a_done_fell: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result strobe without end of work");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !evicted)
        else $error("hit reported with eviction");

    // Result fields are fully defined while the strobe is up
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({hit, slot, evicted}))
        else $error("result fields unknown during strobe");

endmodule

bind move_to_front_key_cache mtfkc_checker u_mtfkc_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .slot    (slot),
    .evicted (evicted)
);

// ----- dv/move_to_front_key_cache_test.sv -----
// Self-checking testbench for move_to_front_key_cache: directed key table, then
// random lookups from a shifting pool of keys, checked against an LRU predictor.
// Depends on mtfkc_pkg and the move_to_front_key_cache RTL.
module move_to_front_key_cache_test;
    import mtfkc_pkg::*;

    localparam int ENTRIES       = MTFKC_ENTRIES;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int POOL_MAX      = 48;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 2 * ENTRIES + 8;
    localparam logic [X_W-1:0]   X_ONES = '1;
    localparam logic [Y_W-1:0]   Y_ONES = '1;
    localparam logic [LVL_W-1:0] L_ONES = '1;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } lookup_result_t;

    // One directed item; typed rows carry an expectation read off by hand
    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [LVL_W-1:0] lv;
        logic             typed;
        lookup_result_t   want;
    } lookup_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam lookup_row_t DIRECTED[DIRECTED_ROWS] = '{
        // first key after reset goes to the lowest free slot
        '{32'h0, 32'h0, 16'h0, 1'b1, '{1'b0, 4'd0, 1'b0}},
        // hit on the most recent entry
        '{32'h0, 32'h0, 16'h0, 1'b1, '{1'b1, 4'd0, 1'b0}},
        '{X_ONES, Y_ONES, L_ONES, 1'b1, '{1'b0, 4'd1, 1'b0}},
        // keys that differ from an existing one in a single field
        '{32'h0, 32'h0, 16'h1, 1'b1, '{1'b0, 4'd2, 1'b0}},
        '{32'h0, 32'h1, 16'h0, 1'b1, '{1'b0, 4'd3, 1'b0}},
        '{32'h1, 32'h0, 16'h0, 1'b1, '{1'b0, 4'd4, 1'b0}},
        '{X_ONES, Y_ONES, 16'hfffe, 1'b1, '{1'b0, 4'd5, 1'b0}},
        '{32'h8000_0000, 32'h0, 16'h0, 1'b1, '{1'b0, 4'd6, 1'b0}},
        '{32'h0, 32'h8000_0000, 16'h0, 1'b1, '{1'b0, 4'd7, 1'b0}},
        '{32'h0, 32'h0, 16'h8000, 1'b1, '{1'b0, 4'd8, 1'b0}},
        // hit on an older entry
        '{X_ONES, Y_ONES, L_ONES, 1'b1, '{1'b1, 4'd1, 1'b0}},
        // fill the remaining free slots
        '{32'h10, 32'h20, 16'h3, 1'b1, '{1'b0, 4'd9, 1'b0}},
        '{32'h11, 32'h21, 16'h3, 1'b1, '{1'b0, 4'd10, 1'b0}},
        '{32'h12, 32'h22, 16'h3, 1'b1, '{1'b0, 4'd11, 1'b0}},
        '{32'h13, 32'h23, 16'h3, 1'b1, '{1'b0, 4'd12, 1'b0}},
        '{32'h14, 32'h24, 16'h3, 1'b1, '{1'b0, 4'd13, 1'b0}},
        '{32'h15, 32'h25, 16'h3, 1'b1, '{1'b0, 4'd14, 1'b0}},
        '{32'h16, 32'h26, 16'h3, 1'b1, '{1'b0, 4'd15, 1'b0}},
        // oldest entry promoted while the store is full
        '{32'h0, 32'h0, 16'h0, 1'b1, '{1'b1, 4'd0, 1'b0}},
        // two misses on a full store evict the LRU entries; two hits follow
        '{32'h100, 32'h100, 16'h100, 1'b0, '{1'b0, 4'd0, 1'b0}},
        '{32'h0, 32'h0, 16'h1, 1'b0, '{1'b0, 4'd0, 1'b0}},
        '{32'h100, 32'h100, 16'h100, 1'b0, '{1'b0, 4'd0, 1'b0}},
        '{32'h10, 32'h20, 16'h3, 1'b0, '{1'b0, 4'd0, 1'b0}}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [X_W-1:0]    tile_x = '0;
    logic [Y_W-1:0]    tile_y = '0;
    logic [LVL_W-1:0]  zoom_level = '0;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;

    move_to_front_key_cache uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .tile_x     (tile_x),
        .tile_y     (tile_y),
        .zoom_level (zoom_level),
        .done       (done),
        .hit        (hit),
        .slot       (slot),
        .evicted    (evicted)
    );

    always #2 clk = ~clk;

    // Shadow copy of the cache contents and recency order (0 = most recent)
    logic [X_W-1:0]   shadow_x[ENTRIES];
    logic [Y_W-1:0]   shadow_y[ENTRIES];
    logic [LVL_W-1:0] shadow_lv[ENTRIES];
    bit               shadow_valid[ENTRIES];
    int unsigned      shadow_rank[ENTRIES];

    lookup_result_t pending_lookups[$];
    int             mismatch_count = 0;
    bit             burst_mode = 1'b0;

    // Key pool for the random part
    logic [X_W-1:0]   pool_x[POOL_MAX];
    logic [Y_W-1:0]   pool_y[POOL_MAX];
    logic [LVL_W-1:0] pool_lv[POOL_MAX];
    int               pool_n = 8;

    // Look a key up in the shadow cache, update recency, return the outcome
    function automatic lookup_result_t cache_lookup(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y,
                                                    input logic [LVL_W-1:0] lv);
        lookup_result_t r;
        int             found_idx;
        int             free_idx;
        int             lru_idx;
        int             target;
        int unsigned    lru_rank;
        int unsigned    age_limit;
        found_idx = -1;
        free_idx  = -1;
        lru_idx   = 0;
        lru_rank  = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i])
            begin
                if (found_idx < 0 && shadow_x[i] == x && shadow_y[i] == y
                    && shadow_lv[i] == lv)
                    found_idx = i;
                // ties go to the highest index
                if (shadow_rank[i] >= lru_rank)
                begin
                    lru_rank = shadow_rank[i];
                    lru_idx  = i;
                end
            end
            else if (free_idx < 0)
                free_idx = i;
        end

        r.evicted = 1'b0;
        if (found_idx >= 0)
        begin
            target    = found_idx;
            age_limit = shadow_rank[found_idx];
            r.hit     = 1'b1;
        end
        else
        begin
            r.hit     = 1'b0;
            age_limit = 32'hffff_ffff;
            if (free_idx >= 0)
                target = free_idx;
            else
            begin
                target = lru_idx;
                r.evicted = 1'b1;
                shadow_valid[target] = 1'b0;
            end
        end

        // everything more recent than the target moves one step toward LRU
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < age_limit)
                shadow_rank[i]++;

        shadow_x[target]     = x;
        shadow_y[target]     = y;
        shadow_lv[target]    = lv;
        shadow_valid[target] = 1'b1;
        shadow_rank[target]  = 0;
        r.slot = target[SLOT_W-1:0];
        return r;
    endfunction

    // Sender idle time: mostly short, a few long, none in a burst
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 5);
        else if (r < 95)
            return $urandom_range(6, 40);
        return $urandom_range(41, 100);
    endfunction

    // Field value biased toward the extremes
    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item after a random gap and hold it until it is taken
    task automatic send_key(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic [LVL_W-1:0] lv, input bit typed,
                            input lookup_result_t want);
        int             gap;
        lookup_result_t outcome;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                // junk on the key ports while start is low
                tile_x     <= $urandom;
                tile_y     <= $urandom;
                zoom_level <= LVL_W'($urandom);
                @(posedge clk);
            end
        end
        start      <= 1'b1;
        tile_x     <= x;
        tile_y     <= y;
        zoom_level <= lv;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        outcome = cache_lookup(x, y, lv);
        pending_lookups.push_back(typed ? want : outcome);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result hit=%b slot=%0d evicted=%b",
                         $time, hit, slot, evicted);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_lookups.pop_front();
                if (hit !== exp_r.hit || slot !== exp_r.slot
                    || evicted !== exp_r.evicted)
                begin
                    $display("%0t: mismatch expected hit=%b slot=%0d evicted=%b,",
                             $time, exp_r.hit, exp_r.slot, exp_r.evicted,
                             " got hit=%b slot=%0d evicted=%b", hit, slot, evicted);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        int quiet_cycles;
        if ((rst_n && start && busy === 1'b0) || done === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("move_to_front_key_cache_test NOT OK");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        lookup_result_t none;
        logic [X_W-1:0]   kx;
        logic [Y_W-1:0]   ky;
        logic [LVL_W-1:0] kl;
        int               pick;
        int               sel;
        none = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        for (int i = 0; i < POOL_MAX; i++)
        begin
            pool_x[i]  = $urandom;
            pool_y[i]  = $urandom;
            pool_lv[i] = LVL_W'($urandom);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_key(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].lv,
                     DIRECTED[r].typed, DIRECTED[r].want);

        // random lookups drawn mostly from a pool, so hits and evictions mix
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pool_n = $urandom_range(2, ENTRIES - 1);
                    1: pool_n = ENTRIES;
                    2: pool_n = $urandom_range(ENTRIES + 1, ENTRIES + 8);
                    default: pool_n = $urandom_range(ENTRIES + 9, POOL_MAX);
                endcase
            end
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);

            pick = $urandom_range(0, pool_n - 1);
            kx = pool_x[pick];
            ky = pool_y[pick];
            kl = pool_lv[pick];
            sel = $urandom_range(0, 99);
            if (sel >= 70 && sel < 80)
            begin
                // near miss: one bit off a known key
                case ($urandom_range(0, 2))
                    0: kx = kx ^ (32'h1 << $urandom_range(0, X_W - 1));
                    1: ky = ky ^ (32'h1 << $urandom_range(0, Y_W - 1));
                    default: kl = kl ^ (16'h1 << $urandom_range(0, LVL_W - 1));
                endcase
            end
            else if (sel >= 80)
            begin
                // fresh key replaces a pool entry
                if (sel < 90)
                begin
                    kx = $urandom;
                    ky = $urandom;
                    kl = LVL_W'($urandom);
                end
                else
                begin
                    kx = edge_word();
                    ky = edge_word();
                    kl = LVL_W'(edge_word());
                end
                pool_x[pick]  = kx;
                pool_y[pick]  = ky;
                pool_lv[pick] = kl;
            end
            send_key(kx, ky, kl, 1'b0, none);
        end
        start <= 1'b0;

        // drain outstanding results, then give the block time to misbehave
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("move_to_front_key_cache_test OK");
        else
            $display("move_to_front_key_cache_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mtfkc_pkg.sv
sv/mtfkc_ctrl.sv
sv/mtfkc_dpath.sv
sv/move_to_front_key_cache.sv
sv/mtfkc_checker.sv
dv/move_to_front_key_cache_test.sv
